FILE: sv/mfc_pkg.sv
// ----------------------------------------------------------------------------
// mfc_pkg
// Types, constants and the CRC-16/MODBUS byte update for the frame checker.
// ----------------------------------------------------------------------------
package mfc_pkg;

    localparam int unsigned MAX_FRAME = 64;
    localparam int unsigned CNT_W     = 7;

    localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] COUNT_MIN = CNT_W'(3);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

    localparam logic [1:0] CFG_EXPECTED_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_FIRST_WORD_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_SECOND_WORD_OFFSET = 2'd2;

    localparam logic [6:0] RST_EXPECTED_LENGTH    = 7'd17;
    localparam logic [5:0] RST_FIRST_WORD_OFFSET  = 6'd3;
    localparam logic [5:0] RST_SECOND_WORD_OFFSET = 6'd11;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      first_word;
        logic [31:0]      second_word;
        logic [CNT_W-1:0] byte_count;
    } t_out;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic in_window(input logic [CNT_W-1:0] pos, input logic [5:0] off);
        logic [CNT_W-1:0] diff;
        diff = pos - {1'b0, off};
        return (pos >= {1'b0, off}) && (diff < CNT_W'(4));
    endfunction

endpackage

FILE: sv/modbus_frame_checker_top.sv
// ----------------------------------------------------------------------------
// modbus_frame_checker_top
// Byte-serial frame checker: CRC-16/MODBUS, length check, two word captures.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+---------------------------------
//  input    | i_in_valid  | o_in_stall  | i_in  (t_in: rx_byte, frame_end)
//  result   | o_out_valid | i_out_stall | o_out (t_out)
//  config   | i_cfg_we    | -           | i_cfg_index, i_cfg_data
//
//  One byte per cycle when not stalled; the CRC step of the byte leaving
//  the two-byte delay line is one unrolled 8-bit update between the state
//  registers. A result appears in the cycle after its last byte is taken.
//  Reset restores the registers to 17/3/11 and clears all frame state.
//  A last byte is held off only while a previous result still waits.
// ----------------------------------------------------------------------------
module modbus_frame_checker_top
    import mfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    logic [6:0]       r_exp_len;
    logic [5:0]       r_off_one;
    logic [5:0]       r_off_two;

    logic [15:0]      r_crc,   n_crc;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_word_one, n_word_one;
    logic [31:0]      r_word_two, n_word_two;
    logic [15:0]      r_rcrc,  n_rcrc;

    logic             r_out_valid;
    t_out             r_out, n_out;

    logic             in_accept;

    assign o_in_stall  = r_out_valid && i_out_stall && i_in.frame_end;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= RST_EXPECTED_LENGTH;
            r_off_one <= RST_FIRST_WORD_OFFSET;
            r_off_two <= RST_SECOND_WORD_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_LENGTH:    r_exp_len <= i_cfg_data;
                CFG_FIRST_WORD_OFFSET:  r_off_one <= i_cfg_data[5:0];
                CFG_SECOND_WORD_OFFSET: r_off_two <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_word_one = r_word_one;
        n_word_two = r_word_two;
        if (in_window(r_count, r_off_one)) begin
            n_word_one = {r_word_one[23:0], i_in.rx_byte};
        end
        if (in_window(r_count, r_off_two)) begin
            n_word_two = {r_word_two[23:0], i_in.rx_byte};
        end
        n_crc = (r_count >= CNT_W'(2)) ? crc_byte(r_crc, r_rcrc[7:0]) : r_crc;
        n_rcrc  = {i_in.rx_byte, r_rcrc[15:8]};
        n_count = (r_count < COUNT_SAT) ? r_count + CNT_W'(1) : r_count;

        n_out.first_word  = n_word_one;
        n_out.second_word = n_word_two;
        n_out.byte_count  = n_count;
        if (n_count != r_exp_len || n_count < COUNT_MIN || n_count > COUNT_MAX) begin
            n_out.status = STATUS_LEN_ERR;
        end else if (n_crc != n_rcrc) begin
            n_out.status = STATUS_CRC_ERR;
        end else begin
            n_out.status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_count    <= '0;
            r_word_one <= '0;
            r_word_two <= '0;
            r_rcrc     <= '0;
        end else if (in_accept) begin
            if (i_in.frame_end) begin
                r_crc      <= CRC_INIT;
                r_count    <= '0;
                r_word_one <= '0;
                r_word_two <= '0;
                r_rcrc     <= '0;
            end else begin
                r_crc      <= n_crc;
                r_count    <= n_count;
                r_word_one <= n_word_one;
                r_word_two <= n_word_two;
                r_rcrc     <= n_rcrc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_in.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in.frame_end) begin
            r_out <= n_out;
        end
    end

    a_stall_only_when_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with no pending result");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_SAT)
        else $error("byte count beyond saturation");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.frame_end) |=> (r_count == '0 && r_crc == CRC_INIT && r_out_valid))
        else $error("frame state not restarted after last byte");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost or changed");

endmodule

FILE: sim/frame_check_monitor.sv
// ----------------------------------------------------------------------------
// frame_check_monitor
// Watches the byte, result and register ports of the frame checker. It keeps
// its own copy of the frame state (running CRC-16/MODBUS, two-byte CRC tail,
// byte count, word captures) and register values, and predicts one verdict
// per last byte. It compares each result transfer field by field against the
// oldest pending verdict, and reports the pending depth and mismatch count.
// ----------------------------------------------------------------------------
module frame_check_monitor
    import mfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in        i_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out       i_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    output int         o_pending,
    output int         o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [6:0]  len_reg;
    logic [5:0]  off_first;
    logic [5:0]  off_second;

    logic [15:0] crc_run;
    logic [15:0] crc_tail;
    logic [6:0]  bytes_seen;
    logic [31:0] word_first;
    logic [31:0] word_second;

    t_out        verdicts [$];
    int          mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [15:0] modbus_crc_shift(input logic [15:0] acc,
                                                     input logic [7:0] data);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ data[k]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic void restart_frame();
        crc_run     = CRC_INIT;
        crc_tail    = '0;
        bytes_seen  = '0;
        word_first  = '0;
        word_second = '0;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic absorb_byte(input t_in item);
        t_out verdict;
        int   rel_first;
        int   rel_second;
        rel_first  = int'(bytes_seen) - int'(off_first);
        rel_second = int'(bytes_seen) - int'(off_second);
        if (rel_first >= 0 && rel_first < 4) begin
            word_first = {word_first[23:0], item.rx_byte};
        end
        if (rel_second >= 0 && rel_second < 4) begin
            word_second = {word_second[23:0], item.rx_byte};
        end
        // fold the byte leaving the CRC tail
        if (bytes_seen >= 7'd2) begin
            crc_run = modbus_crc_shift(crc_run, crc_tail[7:0]);
        end
        crc_tail = {item.rx_byte, crc_tail[15:8]};
        if (bytes_seen <= 7'(MAX_FRAME)) begin
            bytes_seen = bytes_seen + 7'd1;
        end
        if (item.frame_end) begin
            if (bytes_seen != len_reg || bytes_seen < 7'd3 || bytes_seen > 7'(MAX_FRAME)) begin
                verdict.status = STATUS_LEN_ERR;
            end else if (crc_run != crc_tail) begin
                verdict.status = STATUS_CRC_ERR;
            end else begin
                verdict.status = STATUS_OK;
            end
            verdict.first_word  = word_first;
            verdict.second_word = word_second;
            verdict.byte_count  = bytes_seen;
            verdicts.push_back(verdict);
            restart_frame();
        end
    endtask

    task automatic check_verdict(input t_out got);
        t_out want;
        if (verdicts.size() == 0) begin
            report("unexpected result, status", 32'(got.status), 32'(STATUS_OK));
        end else begin
            want = verdicts.pop_front();
            if (got.status !== want.status) begin
                report("status", 32'(got.status), 32'(want.status));
            end
            if (got.first_word !== want.first_word) begin
                report("first_word", got.first_word, want.first_word);
            end
            if (got.second_word !== want.second_word) begin
                report("second_word", got.second_word, want.second_word);
            end
            if (got.byte_count !== want.byte_count) begin
                report("byte_count", 32'(got.byte_count), 32'(want.byte_count));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_reg    = RST_EXPECTED_LENGTH;
            off_first  = RST_FIRST_WORD_OFFSET;
            off_second = RST_SECOND_WORD_OFFSET;
            restart_frame();
            verdicts.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_verdict(i_out);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPECTED_LENGTH: begin
                        len_reg = i_cfg_data;
                    end
                    CFG_FIRST_WORD_OFFSET: begin
                        off_first = i_cfg_data[5:0];
                    end
                    CFG_SECOND_WORD_OFFSET: begin
                        off_second = i_cfg_data[5:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_byte(i_in);
            end
        end
        o_pending <= verdicts.size();
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Frame checker testbench. Resets the block, sends a few directed frames
// (extreme bytes, one- and two-byte frames, minimum length with good and bad
// CRC), then phases of edge or random register settings, each a run of frames:
// mostly well-formed with a valid CRC, some with a flipped bit, some of random
// length, some past the length limit. Both sides idle at random per phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mfc_pkg::*;

    localparam int         ITEM_TARGET = 1650;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in        in_item;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out       out_item;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    int         pending;
    int         mismatches;
    int         cycle_count = 0;
    int         bytes_sent = 0;
    int         out_hold = 0;
    int         cur_len = int'(RST_EXPECTED_LENGTH);
    bit         sender_idles = 1'b1;
    bit         receiver_stalls = 1'b1;

    modbus_frame_checker_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    frame_check_monitor u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // hold off the result side for a random stretch after each transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            out_hold = 0;
            out_stall <= 1'b0;
        end else if (out_valid && !out_stall) begin
            out_hold = receiver_stalls ? $urandom_range(0, 12) : 0;
            out_stall <= (out_hold != 0);
        end else if (out_hold != 0) begin
            out_hold--;
            out_stall <= (out_hold != 0);
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = sender_idles ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{rx_byte: data, frame_end: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_frame(input int n, input bit with_crc, input bit corrupt,
                              input bit alternate);
        logic [7:0]  frame_bytes [$];
        logic [7:0]  data;
        logic [15:0] crc;
        int          pos;
        crc = CRC_INIT;
        for (int k = 0; k < n; k++) begin
            if (with_crc && k == n - 2) begin
                frame_bytes.push_back(crc[7:0]);
            end else if (with_crc && k == n - 1) begin
                frame_bytes.push_back(crc[15:8]);
            end else begin
                data = alternate ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom);
                frame_bytes.push_back(data);
                crc = crc_byte(crc, data);
            end
        end
        if (corrupt) begin
            pos = $urandom_range(0, n - 1);
            frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int k = 0; k < n; k++) begin
            send_byte(frame_bytes[k], k == n - 1);
        end
        bytes_sent += n;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [6:0] len, input logic [6:0] first,
                             input logic [6:0] second);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cfg_index <= CFG_FIRST_WORD_OFFSET;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= CFG_SECOND_WORD_OFFSET;
        cfg_data  <= second;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 7'($urandom);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_len = int'(len);
    endtask

    initial begin
        int pick;
        int n;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_EXPECTED_LENGTH;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(int'(RST_EXPECTED_LENGTH), 1'b1, 1'b0, 1'b1);
        send_frame(1, 1'b0, 1'b0, 1'b0);
        send_frame(2, 1'b0, 1'b0, 1'b1);
        settle();
        configure(7'd3, 7'd0, 7'd60);
        send_frame(3, 1'b1, 1'b0, 1'b1);
        send_frame(3, 1'b1, 1'b1, 1'b0);

        for (int phase = 0; bytes_sent < ITEM_TARGET; phase++) begin
            settle();
            case (phase)
                0: configure(7'd64, 7'd60, 7'd0);
                1: configure(7'd0, 7'd63, 7'($urandom));
                2: configure(7'd127, 7'($urandom), 7'd60);
                3: configure(7'd3, 7'($urandom), 7'($urandom));
                default: begin
                    configure(($urandom_range(0, 7) == 0) ? 7'($urandom)
                                                          : 7'($urandom_range(3, MAX_FRAME)),
                              7'($urandom), 7'($urandom));
                end
            endcase
            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            if (phase == 0) begin
                send_frame($urandom_range(MAX_FRAME + 2, MAX_FRAME + 16), 1'b1, 1'b0, 1'b0);
            end
            repeat ($urandom_range(6, 12)) begin
                pick = $urandom_range(0, 99);
                n = (cur_len >= 3 && cur_len <= MAX_FRAME) ? cur_len
                                                           : $urandom_range(3, MAX_FRAME);
                if (pick < 60) begin
                    send_frame(n, 1'b1, 1'b0, 1'b0);
                end else if (pick < 75) begin
                    send_frame(n, 1'b1, 1'b1, 1'b0);
                end else if (pick < 93) begin
                    send_frame($urandom_range(1, MAX_FRAME + 4), 1'($urandom), 1'b0, 1'b0);
                end else begin
                    send_frame($urandom_range(MAX_FRAME + 1, MAX_FRAME + 24), 1'b1, 1'b0,
                               1'b0);
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: modbus_frame_checker_top.f
sv/mfc_pkg.sv
sv/modbus_frame_checker_top.sv
sim/frame_check_monitor.sv
sim/tb.sv
